// File: src/interval_length_record_quicksort_defines.svh
// assertion macros for the interval length record sorter
`ifndef INTERVAL_LENGTH_RECORD_QUICKSORT_DEFINES_SVH
`define INTERVAL_LENGTH_RECORD_QUICKSORT_DEFINES_SVH

// same-cycle implication
`define ILRQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ILRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ilrq_pkg.sv
// shared types and command/status structs for the interval length record sorter
`timescale 1ns / 1ps
package ilrq_pkg;

    typedef struct packed {
        logic signed [31:0] interval_start;
        logic signed [31:0] interval_end;
        logic signed [31:0] payload_a;
        logic signed [31:0] payload_b;
        logic               last_record;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_start;
        logic signed [31:0] out_end;
        logic signed [31:0] out_payload_a;
        logic signed [31:0] out_payload_b;
        logic               out_last;
        logic               overflow;
    } t_out_item;

    typedef enum logic [2:0] {
        A_MID,
        A_LO,
        A_I,
        A_LAST,
        A_LAST1,
        A_K
    } t_addr_sel;

    typedef enum logic [1:0] {
        SRC_RDATA,
        SRC_HOLD,
        SRC_PIVOT
    } t_wr_src;

    typedef struct packed {
        logic      load;
        logic      rd_en;
        t_addr_sel rd_sel;
        logic      wr_en;
        t_addr_sel wr_sel;
        t_wr_src   wr_src;
        logic      pivot_ld;
        logic      hold_ld;
        logic      scan_init;
        logic      i_inc;
        logic      last_inc;
        logic      push_init;
        logic      pop_rd;
        logic      pop_ld;
        logic      push_left;
        logic      push_right;
        logic      emit_init;
        logic      k_inc;
        logic      out_ld;
        logic      batch_clr;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic count_lt2;
        logic stack_empty;
        logic i_gt_hi;
        logic less;
        logic last_gt_lo;
        logic out_taken;
        logic k_last;
    } t_status;

endpackage

// File: src/ilrq_dp.sv
// datapath: record store, range stack, pivot, indices and output register
`timescale 1ns / 1ps
module ilrq_dp import ilrq_pkg::*; #(
    parameter int MAX_RECORDS = 64,
    parameter int WORD_BITS   = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  t_cmd      i_cmd,
    input  logic      i_out_stall,
    output t_status   o_status,
    output logic      o_out_valid,
    output t_out_item o_out
);
    localparam int IW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int RW = 4 * WORD_BITS;
    localparam int SW = 2 * IW;

    logic [RW-1:0] r_mem [MAX_RECORDS];
    logic [SW-1:0] r_stk [MAX_RECORDS];
    logic [RW-1:0] r_rdata, r_hold, r_pivot;
    logic [SW-1:0] r_srdata;
    logic [CW-1:0] r_count, r_sp, r_lo, r_hi, r_i, r_last, r_k;
    logic          r_drop;
    logic          r_out_valid;
    t_out_item     r_out;

    logic [CW:0]   w_sum;
    logic [CW-1:0] w_mid, w_raddr, w_waddr;
    logic [RW-1:0] w_in_rec, w_wdata;
    logic          w_full, w_wr;
    logic          w_push;
    logic [SW-1:0] w_push_data;

    function automatic logic [CW-1:0] f_addr(input t_addr_sel sel, input logic [CW-1:0] mid,
                                             input logic [CW-1:0] lo, input logic [CW-1:0] i,
                                             input logic [CW-1:0] last, input logic [CW-1:0] k);
        logic [CW-1:0] a;
        case (sel)
            A_MID:   a = mid;
            A_LO:    a = lo;
            A_I:     a = i;
            A_LAST:  a = last;
            A_LAST1: a = last + CW'(1);
            A_K:     a = k;
            default: a = i;
        endcase
        return a;
    endfunction

    // interval length minus one, one bit wider than a word
    function automatic logic signed [WORD_BITS:0] f_key(input logic [RW-1:0] rec);
        logic signed [WORD_BITS:0] s;
        logic signed [WORD_BITS:0] e;
        s = {rec[WORD_BITS-1], rec[WORD_BITS-1:0]};
        e = {rec[2*WORD_BITS-1], rec[2*WORD_BITS-1:WORD_BITS]};
        return e - s;
    endfunction

    assign w_sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid    = w_sum[CW:1];
    assign w_raddr  = f_addr(i_cmd.rd_sel, w_mid, r_lo, r_i, r_last, r_k);
    assign w_full   = (r_count == CW'(MAX_RECORDS));
    assign w_in_rec = {WORD_BITS'(i_in.payload_b), WORD_BITS'(i_in.payload_a),
                       WORD_BITS'(i_in.interval_end), WORD_BITS'(i_in.interval_start)};

    always_comb begin
        w_wr    = i_cmd.wr_en;
        w_waddr = f_addr(i_cmd.wr_sel, w_mid, r_lo, r_i, r_last, r_k);
        case (i_cmd.wr_src)
            SRC_RDATA: w_wdata = r_rdata;
            SRC_HOLD:  w_wdata = r_hold;
            SRC_PIVOT: w_wdata = r_pivot;
            default:   w_wdata = r_rdata;
        endcase
        if (i_cmd.load) begin
            w_wr    = !w_full;
            w_waddr = r_count;
            w_wdata = w_in_rec;
        end
    end

    // range pushes, one per cycle
    always_comb begin
        w_push      = 1'b0;
        w_push_data = '0;
        if (i_cmd.push_init) begin
            w_push      = 1'b1;
            w_push_data = {IW'(0), IW'(r_count - CW'(1))};
        end else if (i_cmd.push_left) begin
            w_push      = ({1'b0, r_last} > ({1'b0, r_lo} + (CW+1)'(1)));
            w_push_data = {r_lo[IW-1:0], IW'(r_last - CW'(1))};
        end else if (i_cmd.push_right) begin
            w_push      = (({1'b0, r_last} + (CW+1)'(1)) < {1'b0, r_hi});
            w_push_data = {IW'(r_last + CW'(1)), r_hi[IW-1:0]};
        end
        if (r_sp >= CW'(MAX_RECORDS)) begin
            w_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[w_waddr[IW-1:0]] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_raddr[IW-1:0]];
        end
        if (w_push) begin
            r_stk[r_sp[IW-1:0]] <= w_push_data;
        end
        if (i_cmd.pop_rd) begin
            r_srdata <= r_stk[IW'(r_sp - CW'(1))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pivot_ld) begin
            r_pivot <= r_rdata;
        end
        if (i_cmd.hold_ld) begin
            r_hold <= r_rdata;
        end
        if (i_cmd.pop_ld) begin
            r_lo <= CW'(r_srdata[SW-1:IW]);
            r_hi <= CW'(r_srdata[IW-1:0]);
        end
        if (i_cmd.scan_init) begin
            r_i    <= r_lo + CW'(1);
            r_last <= r_lo;
        end else begin
            if (i_cmd.i_inc) begin
                r_i <= r_i + CW'(1);
            end
            if (i_cmd.last_inc) begin
                r_last <= r_last + CW'(1);
            end
        end
        if (i_cmd.emit_init) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + CW'(1);
        end
        if (i_cmd.out_ld) begin
            r_out.out_start     <= 32'($signed(r_rdata[WORD_BITS-1:0]));
            r_out.out_end       <= 32'($signed(r_rdata[2*WORD_BITS-1:WORD_BITS]));
            r_out.out_payload_a <= 32'($signed(r_rdata[3*WORD_BITS-1:2*WORD_BITS]));
            r_out.out_payload_b <= 32'($signed(r_rdata[4*WORD_BITS-1:3*WORD_BITS]));
            r_out.out_last      <= (r_k == r_count - CW'(1));
            r_out.overflow      <= r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sp        <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.batch_clr) begin
                r_count <= '0;
                r_sp    <= '0;
                r_drop  <= 1'b0;
            end else begin
                if (i_cmd.load) begin
                    if (w_full) begin
                        r_drop <= 1'b1;
                    end else begin
                        r_count <= r_count + CW'(1);
                    end
                end
                if (w_push) begin
                    r_sp <= r_sp + CW'(1);
                end else if (i_cmd.pop_rd) begin
                    r_sp <= r_sp - CW'(1);
                end
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.count_zero  = (r_count == '0);
    assign o_status.count_lt2   = (r_count < CW'(2));
    assign o_status.stack_empty = (r_sp == '0);
    assign o_status.i_gt_hi     = (r_i > r_hi);
    assign o_status.less        = (f_key(r_rdata) < f_key(r_pivot));
    assign o_status.last_gt_lo  = (r_last > r_lo);
    assign o_status.out_taken   = r_out_valid && !i_out_stall;
    assign o_status.k_last      = (r_k == r_count - CW'(1));

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: src/ilrq_ctrl.sv
// controller: load, quicksort sequencing and emit state machine
`timescale 1ns / 1ps
module ilrq_ctrl import ilrq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);
    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_POP, S_POPW, S_PIVR, S_PIVL, S_MOV, S_SCAN, S_CMP,
        S_SW1, S_SW2, S_FIN1, S_FIN2, S_PUSHR, S_EMR, S_EML, S_EMW
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        w_cmd.rd_sel = A_I;
        w_cmd.wr_sel = A_I;
        w_cmd.wr_src = SRC_RDATA;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    if (i_in_last) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                if (i_status.count_zero) begin
                    w_cmd.batch_clr = 1'b1;
                    n_state = S_IDLE;
                end else if (i_status.count_lt2) begin
                    w_cmd.emit_init = 1'b1;
                    n_state = S_EMR;
                end else begin
                    w_cmd.push_init = 1'b1;
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (i_status.stack_empty) begin
                    w_cmd.emit_init = 1'b1;
                    n_state = S_EMR;
                end else begin
                    w_cmd.pop_rd = 1'b1;
                    n_state = S_POPW;
                end
            end
            S_POPW: begin
                w_cmd.pop_ld = 1'b1;
                n_state = S_PIVR;
            end
            S_PIVR: begin
                w_cmd.rd_en  = 1'b1;
                w_cmd.rd_sel = A_MID;
                n_state = S_PIVL;
            end
            S_PIVL: begin
                w_cmd.pivot_ld = 1'b1;
                w_cmd.rd_en    = 1'b1;
                w_cmd.rd_sel   = A_LO;
                n_state = S_MOV;
            end
            S_MOV: begin
                w_cmd.wr_en     = 1'b1;
                w_cmd.wr_sel    = A_MID;
                w_cmd.scan_init = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                w_cmd.rd_en = 1'b1;
                if (i_status.i_gt_hi) begin
                    w_cmd.rd_sel = A_LAST;
                    n_state = S_FIN1;
                end else begin
                    w_cmd.rd_sel = A_I;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_status.less) begin
                    w_cmd.hold_ld = 1'b1;
                    w_cmd.rd_en   = 1'b1;
                    w_cmd.rd_sel  = A_LAST1;
                    n_state = S_SW1;
                end else begin
                    w_cmd.i_inc = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SW1: begin
                w_cmd.wr_en  = 1'b1;
                w_cmd.wr_sel = A_LAST1;
                w_cmd.wr_src = SRC_HOLD;
                n_state = S_SW2;
            end
            S_SW2: begin
                w_cmd.wr_en    = 1'b1;
                w_cmd.wr_sel   = A_I;
                w_cmd.i_inc    = 1'b1;
                w_cmd.last_inc = 1'b1;
                n_state = S_SCAN;
            end
            S_FIN1: begin
                w_cmd.wr_en  = i_status.last_gt_lo;
                w_cmd.wr_sel = A_LO;
                n_state = S_FIN2;
            end
            S_FIN2: begin
                w_cmd.wr_en     = 1'b1;
                w_cmd.wr_sel    = A_LAST;
                w_cmd.wr_src    = SRC_PIVOT;
                w_cmd.push_left = 1'b1;
                n_state = S_PUSHR;
            end
            S_PUSHR: begin
                w_cmd.push_right = 1'b1;
                n_state = S_POP;
            end
            S_EMR: begin
                w_cmd.rd_en  = 1'b1;
                w_cmd.rd_sel = A_K;
                n_state = S_EML;
            end
            S_EML: begin
                w_cmd.out_ld = 1'b1;
                n_state = S_EMW;
            end
            S_EMW: begin
                if (i_status.out_taken) begin
                    if (i_status.k_last) begin
                        w_cmd.batch_clr = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        w_cmd.k_inc = 1'b1;
                        n_state = S_EMR;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_cmd      = w_cmd;
    assign o_in_stall = r_busy;

endmodule

// File: src/interval_length_record_quicksort.sv
// after the last record: a start step, the sort, then a store read and an output register load
// loading: one record transfer per cycle; sort: a read and a key compare per scanned record, two
//   writes per swap; per range a pop, pivot and low reads, a move, two end writes and two pushes
// emit: per sorted record a store read, an output load and a wait until taken; then back to loading
// reset: synchronous active low; clears state, record count, stack pointer, drop and valid flags
// store and range stack contents are not cleared and need no clearing pass
`timescale 1ns / 1ps
module interval_length_record_quicksort import ilrq_pkg::*; #(
    parameter int MAX_RECORDS = 64,
    parameter int WORD_BITS   = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // record input channel
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    // sorted record output channel
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);
    // command and status between sequencer and datapath
    t_cmd    w_cmd;
    t_status w_status;

    // sequencer: loading, partition steps, range stack pops/pushes, emit
    ilrq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in.last_record),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // record store, range stack, pivot and the output register
    ilrq_dp #(
        .MAX_RECORDS (MAX_RECORDS),
        .WORD_BITS   (WORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// File: src/ilrq_checker.sv
// port-level checker for the interval length record sorter, with its bind
`timescale 1ns / 1ps
`include "interval_length_record_quicksort_defines.svh"
module ilrq_checker import ilrq_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out
);
    // a stalled result holds
    `ILRQ_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out), "stalled result changed")
    // no loading while results are pending
    `ILRQ_ASSERT_NOW(a_busy_emit, o_out_valid, o_in_stall, "input open during emit")
    // last record closes the batch
    `ILRQ_ASSERT_NEXT(a_last_busy, i_in_valid && !o_in_stall && i_in.last_record, o_in_stall, "no sort after last record")
    // nothing follows the final result of a batch
    `ILRQ_ASSERT_NEXT(a_end_batch, o_out_valid && !i_out_stall && o_out.out_last, !o_out_valid, "result after final record")

endmodule

bind interval_length_record_quicksort ilrq_checker u_ilrq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
